// ===== src/length_prefixed_field_parser_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the length-prefixed field parser
// Shared forms for the concurrent checks in the controller and datapath.
// ---------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FIELD_PARSER_TOP_MACROS_SVH
`define LENGTH_PREFIXED_FIELD_PARSER_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define LPFP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define LPFP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/lpfp_pkg.sv =====
// ---------------------------------------------------------------------------
// Length-prefixed field parser package
// Error codes and the command and status bundles between controller and
// datapath.
// ---------------------------------------------------------------------------
package lpfp_pkg;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_LENGTH = 2'd1,
    ERR_COUNT  = 2'd2,
    ERR_TRUNC  = 2'd3
  } err_t;

  // controller -> datapath
  typedef struct packed {
    logic byte_take;
    logic ld_count;
    logic ld_len_hi;
    logic ld_len_lo;
    logic body;
    logic advance;
    logic drain_clear;
    logic load_record;
    logic load_status;
    logic clear;
    err_t err;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic can_parse;
    logic count_over;
    logic count_zero;
    logic len_zero;
    logic body_end;
    logic fields_done;
    logic bc_bad;
    logic drain_more;
  } dp_status_t;

endpackage

// ===== src/lpfp_ctrl.sv =====
// ---------------------------------------------------------------------------
// Length-prefixed field parser controller
// Parse phase machine, end-of-packet evaluation and record drain sequencing.
// ---------------------------------------------------------------------------
`include "length_prefixed_field_parser_top_macros.svh"

module lpfp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                last_byte,
  output logic                out_valid,
  input  logic                out_ready,
  input  lpfp_pkg::dp_status_t status,
  output lpfp_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    PH_COUNT,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_BODY,
    PH_DONE,
    PH_BAD_COUNT
  } phase_t;

  typedef enum logic [1:0] {
    M_PARSE,
    M_EVAL,
    M_DRAIN
  } mode_t;

  phase_t         phase, phase_next;
  mode_t          mode, mode_next;
  lpfp_pkg::err_t err_q, err_next;
  logic           out_valid_next;
  logic           accept;
  logic           slot_free;

  assign in_ready  = (mode == M_PARSE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd            = '0;
    cmd.err        = err_q;
    phase_next     = phase;
    mode_next      = mode;
    err_next       = err_q;
    cmd.byte_take  = accept;

    if (accept && status.can_parse) begin
      case (phase)
        PH_COUNT: begin
          cmd.ld_count = 1'b1;
          if (status.count_over) begin
            phase_next = PH_BAD_COUNT;
          end else if (status.count_zero) begin
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          cmd.ld_len_hi = 1'b1;
          phase_next    = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          cmd.ld_len_lo = 1'b1;
          if (status.len_zero) begin
            cmd.advance = 1'b1;
            phase_next  = status.fields_done ? PH_DONE : PH_LEN_HI;
          end else begin
            phase_next = PH_BODY;
          end
        end
        PH_BODY: begin
          cmd.body = 1'b1;
          if (status.body_end) begin
            cmd.advance = 1'b1;
            phase_next  = status.fields_done ? PH_DONE : PH_LEN_HI;
          end
        end
        default: begin
        end
      endcase
    end

    case (mode)
      M_PARSE: begin
        if (accept && last_byte) begin
          mode_next = M_EVAL;
        end
      end
      M_EVAL: begin
        cmd.drain_clear = 1'b1;
        if (status.bc_bad) begin
          err_next = lpfp_pkg::ERR_LENGTH;
        end else if (phase == PH_BAD_COUNT) begin
          err_next = lpfp_pkg::ERR_COUNT;
        end else if (phase == PH_DONE) begin
          err_next = lpfp_pkg::ERR_OK;
        end else begin
          err_next = lpfp_pkg::ERR_TRUNC;
        end
        mode_next = M_DRAIN;
      end
      M_DRAIN: begin
        if (slot_free) begin
          if (err_q == lpfp_pkg::ERR_OK && status.drain_more) begin
            cmd.load_record = 1'b1;
          end else begin
            cmd.load_status = 1'b1;
            cmd.clear       = 1'b1;
            phase_next      = PH_COUNT;
            mode_next       = M_PARSE;
          end
        end
      end
      default: begin
        mode_next = M_PARSE;
      end
    endcase

    if (cmd.load_record || cmd.load_status) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_COUNT;
      mode      <= M_PARSE;
      err_q     <= lpfp_pkg::ERR_OK;
      out_valid <= 1'b0;
    end else begin
      phase     <= phase_next;
      mode      <= mode_next;
      err_q     <= err_next;
      out_valid <= out_valid_next;
    end
  end

  // input is held off from the final byte until the status is loaded
  `LPFP_ASSERT_NXT(a_last_blocks_input, clk, rst, accept && last_byte, !in_ready, "input taken right after final byte")
  // field records only ever follow an error-free packet
  `LPFP_ASSERT_IMP(a_record_only_ok, clk, rst, cmd.load_record, err_q == lpfp_pkg::ERR_OK, "record emitted for failed packet")

endmodule

// ===== src/lpfp_dp.sv =====
// ---------------------------------------------------------------------------
// Length-prefixed field parser datapath
// Byte and field counters, per-field record store, tag register and the
// output payload register.
// ---------------------------------------------------------------------------
`include "length_prefixed_field_parser_top_macros.svh"

module lpfp_dp #(
  parameter int FIELD_LIMIT  = 8,
  parameter int PACKET_BYTES = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata,
  input  logic [7:0]           data_byte,
  input  lpfp_pkg::ctrl_cmd_t  cmd,
  output lpfp_pkg::dp_status_t status,
  output logic                 is_status,
  output logic [2:0]           field_index,
  output logic [8:0]           field_offset,
  output logic                 has_value,
  output logic [15:0]          field_value,
  output logic [1:0]           error_kind,
  output logic                 last_result
);

  localparam int BC_W  = $clog2(PACKET_BYTES + 2);
  localparam int CW    = $clog2(FIELD_LIMIT + 1);
  localparam int IDX_W = (FIELD_LIMIT > 1) ? $clog2(FIELD_LIMIT) : 1;

  logic [7:0]      value_tag;
  logic [BC_W-1:0] byte_count;
  logic [7:0]      fields_declared;
  logic [CW-1:0]   field_cursor;
  logic [CW-1:0]   drain_idx;
  logic [7:0]      length_high;
  logic [15:0]     body_remaining;
  logic [1:0]      body_position;
  logic            cur_flag;

  logic [8:0]      rec_offset [FIELD_LIMIT];
  logic [15:0]     rec_value  [FIELD_LIMIT];
  logic            rec_flag   [FIELD_LIMIT];

  logic [IDX_W-1:0] cur_idx;
  logic [IDX_W-1:0] rd_idx;
  logic [BC_W:0]    pos_next;
  logic [BC_W+9:0]  off_wide;
  logic [CW+2:0]    idx_wide;
  logic             tag_hit;

  assign cur_idx  = field_cursor[IDX_W-1:0];
  assign rd_idx   = drain_idx[IDX_W-1:0];
  assign pos_next = {1'b0, byte_count} + 1'b1;
  assign off_wide = {9'b0, pos_next};
  assign idx_wide = {3'b0, drain_idx};
  assign tag_hit  = (data_byte == value_tag) && (body_remaining >= 16'd3);

  always_comb begin
    status             = '0;
    status.can_parse   = byte_count < BC_W'(PACKET_BYTES);
    status.count_over  = data_byte > 8'(FIELD_LIMIT);
    status.count_zero  = data_byte == 8'd0;
    status.len_zero    = {length_high, data_byte} == 16'd0;
    status.body_end    = body_remaining == 16'd1;
    status.fields_done = (9'(field_cursor) + 9'd1) >= {1'b0, fields_declared};
    status.bc_bad      = (byte_count < BC_W'(2)) || (byte_count > BC_W'(PACKET_BYTES));
    status.drain_more  = 9'(drain_idx) < {1'b0, fields_declared};
  end

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      value_tag       <= 8'd1;
      byte_count      <= '0;
      fields_declared <= '0;
      field_cursor    <= '0;
      drain_idx       <= '0;
      length_high     <= '0;
      body_remaining  <= '0;
      body_position   <= '0;
      cur_flag        <= 1'b0;
    end else begin
      if (cfg_we) begin
        value_tag <= cfg_wdata;
      end
      if (cmd.clear) begin
        byte_count      <= '0;
        fields_declared <= '0;
        field_cursor    <= '0;
        length_high     <= '0;
        body_remaining  <= '0;
        body_position   <= '0;
        cur_flag        <= 1'b0;
      end else begin
        if (cmd.byte_take && byte_count <= BC_W'(PACKET_BYTES)) begin
          byte_count <= pos_next[BC_W-1:0];
        end
        if (cmd.ld_count) begin
          fields_declared <= data_byte;
          field_cursor    <= '0;
        end
        if (cmd.ld_len_hi) begin
          length_high <= data_byte;
        end
        if (cmd.ld_len_lo) begin
          body_remaining <= {length_high, data_byte};
          body_position  <= '0;
          cur_flag       <= 1'b0;
        end
        if (cmd.body) begin
          if (body_position == 2'd0) begin
            cur_flag <= tag_hit;
          end
          if (body_position != 2'd3) begin
            body_position <= body_position + 2'd1;
          end
          body_remaining <= body_remaining - 16'd1;
        end
        if (cmd.advance) begin
          field_cursor <= field_cursor + 1'b1;
        end
      end
      if (cmd.drain_clear) begin
        drain_idx <= '0;
      end else if (cmd.load_record) begin
        drain_idx <= drain_idx + 1'b1;
      end
    end
  end

  // record store, undefined until written
  always_ff @(posedge clk) begin
    if (cmd.ld_len_lo) begin
      rec_offset[cur_idx] <= off_wide[8:0];
      rec_flag[cur_idx]   <= 1'b0;
    end
    if (cmd.body) begin
      if (body_position == 2'd0) begin
        rec_flag[cur_idx] <= tag_hit;
      end else if (body_position == 2'd1 && cur_flag) begin
        rec_value[cur_idx][15:8] <= data_byte;
      end else if (body_position == 2'd2 && cur_flag) begin
        rec_value[cur_idx][7:0] <= data_byte;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (cmd.load_record) begin
      is_status    <= 1'b0;
      field_index  <= idx_wide[2:0];
      field_offset <= rec_offset[rd_idx];
      has_value    <= rec_flag[rd_idx];
      field_value  <= rec_flag[rd_idx] ? rec_value[rd_idx] : 16'd0;
      error_kind   <= lpfp_pkg::ERR_OK;
      last_result  <= 1'b0;
    end else if (cmd.load_status) begin
      is_status    <= 1'b1;
      field_index  <= 3'd0;
      field_offset <= 9'd0;
      has_value    <= 1'b0;
      field_value  <= 16'd0;
      error_kind   <= cmd.err;
      last_result  <= 1'b1;
    end
  end

  `LPFP_ASSERT_IMP(a_drain_in_range, clk, rst, cmd.load_record, drain_idx < CW'(FIELD_LIMIT), "drain index past record store")
  `LPFP_ASSERT_IMP(a_write_in_range, clk, rst, cmd.ld_len_lo, field_cursor < CW'(FIELD_LIMIT), "field cursor past record store")

endmodule

// ===== src/length_prefixed_field_parser_top.sv =====
// ---------------------------------------------------------------------------
// Length-prefixed field parser
// Parses a packet of count byte plus length-prefixed fields and reports one
// record per field of an error-free packet, followed by a status transaction.
// ---------------------------------------------------------------------------
// Packet bytes are taken one per cycle while parsing; only the final byte
// costs more. After it the input is held off for an evaluation state plus
// the output transactions (N field records for an error-free packet of N
// fields, then the status; a failed packet gives only the status). The
// drain is paced by the output handshake and the single output register.
// value_tag may be written only while the block is idle.
module length_prefixed_field_parser_top #(
  parameter int FIELD_LIMIT  = 8,
  parameter int PACKET_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_status,
  output logic [2:0]  field_index,
  output logic [8:0]  field_offset,
  output logic        has_value,
  output logic [15:0] field_value,
  output logic [1:0]  error_kind,
  output logic        last_result
);

  lpfp_pkg::ctrl_cmd_t  cmd;
  lpfp_pkg::dp_status_t status;

  lpfp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lpfp_dp #(
    .FIELD_LIMIT  (FIELD_LIMIT),
    .PACKET_BYTES (PACKET_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .data_byte    (data_byte),
    .cmd          (cmd),
    .status       (status),
    .is_status    (is_status),
    .field_index  (field_index),
    .field_offset (field_offset),
    .has_value    (has_value),
    .field_value  (field_value),
    .error_kind   (error_kind),
    .last_result  (last_result)
  );

endmodule

// ===== verif/tb_length_prefixed_field_parser_top.sv =====
// ---------------------------------------------------------------------------
// Length-prefixed field parser testbench
// Feeds packets byte by byte with random idling on both sides, predicts the
// field records and status of every packet, and checks each output
// transaction against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_length_prefixed_field_parser_top;

  localparam int FIELD_LIMIT  = 8;
  localparam int PACKET_BYTES = 256;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_AT      = 20;
  localparam int HOLD_CYCLES  = 300;

  typedef enum {
    AWAIT_COUNT,
    LEN_HIGH,
    LEN_LOW,
    IN_BODY,
    ALL_DONE,
    OVER_COUNT
  } parse_phase_t;

  typedef struct packed {
    logic           status;
    logic [2:0]     index;
    logic [8:0]     offset;
    logic           has_val;
    logic [15:0]    value;
    lpfp_pkg::err_t err;
    logic           last;
  } field_rec_t;

  class parse_scoreboard;
    bit [7:0]     tag;
    parse_phase_t phase;
    int unsigned  byte_cnt;
    int unsigned  declared;
    int unsigned  cursor;
    int unsigned  remaining;
    int unsigned  blen;
    int unsigned  bpos;
    bit [7:0]     len_hi;
    bit [8:0]     offs [FIELD_LIMIT];
    bit [15:0]    vals [FIELD_LIMIT];
    bit           flags [FIELD_LIMIT];
    field_rec_t   expected_records [$];
    int unsigned  mismatches;

    function new();
      tag        = 8'h01;
      mismatches = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      phase     = AWAIT_COUNT;
      byte_cnt  = 0;
      declared  = 0;
      cursor    = 0;
      len_hi    = 8'h00;
      remaining = 0;
      blen      = 0;
      bpos      = 0;
    endfunction

    function void close_field();
      cursor++;
      phase = (cursor >= declared) ? ALL_DONE : LEN_HIGH;
    endfunction

    // predicts the records and status caused by one accepted byte
    function void note_byte(bit [7:0] b, bit last);
      int unsigned    cur;
      bit             cut_short;
      lpfp_pkg::err_t err;
      field_rec_t     rec;
      cur = cursor % FIELD_LIMIT;
      if (byte_cnt < PACKET_BYTES) begin
        case (phase)
          AWAIT_COUNT: begin
            declared = 32'(b);
            cursor   = 0;
            if (b > FIELD_LIMIT) phase = OVER_COUNT;
            else if (b == 0) phase = ALL_DONE;
            else phase = LEN_HIGH;
          end
          LEN_HIGH: begin
            len_hi = b;
            phase  = LEN_LOW;
          end
          LEN_LOW: begin
            blen       = 32'({len_hi, b});
            remaining  = blen;
            bpos       = 0;
            offs[cur]  = 9'(byte_cnt + 1);
            vals[cur]  = 16'h0000;
            flags[cur] = 1'b0;
            if (blen == 0) close_field();
            else phase = IN_BODY;
          end
          IN_BODY: begin
            if (bpos == 0) flags[cur] = (b == tag) && (blen >= 3);
            else if (bpos == 1 && flags[cur]) vals[cur] = {b, 8'h00};
            else if (bpos == 2 && flags[cur]) vals[cur][7:0] = b;
            if (bpos < 3) bpos++;
            remaining--;
            if (remaining == 0) close_field();
          end
          default: begin
          end
        endcase
      end
      // count saturates one past the packet limit
      if (byte_cnt <= PACKET_BYTES) byte_cnt++;
      if (!last) return;

      cut_short = (phase == LEN_HIGH) || (phase == LEN_LOW) || (phase == IN_BODY);
      if (byte_cnt < 2 || byte_cnt > PACKET_BYTES) err = lpfp_pkg::ERR_LENGTH;
      else if (phase == OVER_COUNT) err = lpfp_pkg::ERR_COUNT;
      else if (cut_short || phase == AWAIT_COUNT) err = lpfp_pkg::ERR_TRUNC;
      else err = lpfp_pkg::ERR_OK;

      if (err == lpfp_pkg::ERR_OK) begin
        for (int i = 0; i < declared && i < FIELD_LIMIT; i++) begin
          rec = '{status: 1'b0, index: i[2:0], offset: offs[i], has_val: flags[i],
                  value: flags[i] ? vals[i] : 16'h0000, err: lpfp_pkg::ERR_OK,
                  last: 1'b0};
          expected_records.push_back(rec);
        end
      end
      rec = '{status: 1'b1, index: 3'd0, offset: 9'd0, has_val: 1'b0,
              value: 16'h0000, err: err, last: 1'b1};
      expected_records.push_back(rec);
      clear_packet();
    endfunction

    task report(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
    endtask

    task compare(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_result(field_rec_t got);
      field_rec_t want;
      if (expected_records.size() == 0) begin
        report($sformatf("output transaction %0h with nothing expected", got));
        return;
      end
      want = expected_records.pop_front();
      compare("is_status", got.status, want.status);
      compare("field_index", got.index, want.index);
      compare("field_offset", got.offset, want.offset);
      compare("has_value", got.has_val, want.has_val);
      compare("field_value", got.value, want.value);
      compare("error_kind", got.err, want.err);
      compare("last_result", got.last, want.last);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_ready;
  logic        is_status;
  logic [2:0]  field_index;
  logic [8:0]  field_offset;
  logic        has_value;
  logic [15:0] field_value;
  logic [1:0]  error_kind;
  logic        last_result;

  parse_scoreboard sb = new();
  bit [7:0]        pkt [$];
  bit [7:0]        cur_tag = 8'h01;
  int unsigned     items_sent = 0;

  length_prefixed_field_parser_top #(
    .FIELD_LIMIT (FIELD_LIMIT),
    .PACKET_BYTES(PACKET_BYTES)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .is_status   (is_status),
    .field_index (field_index),
    .field_offset(field_offset),
    .has_value   (has_value),
    .field_value (field_value),
    .error_kind  (error_kind),
    .last_result (last_result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task send_byte(bit [7:0] b, bit last, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b, last);
    items_sent++;
  endtask

  task send_packet(bit burst);
    for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1, burst);
  endtask

  // well-formed field list with random lengths and bodies
  task build_fields(int count);
    int len;
    pkt = {};
    pkt.push_back(8'(count));
    for (int i = 0; i < count; i++) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
      pkt.push_back(8'h00);
      pkt.push_back(8'(len));
      for (int j = 0; j < len; j++) begin
        if (j == 0 && $urandom_range(0, 1)) pkt.push_back(cur_tag);
        else pkt.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task build_random();
    int kind;
    int keep;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      build_fields($urandom_range(0, 8));
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 80) begin
      // ends inside a length or a body
      build_fields($urandom_range(1, 8));
      keep = $urandom_range(2, pkt.size() - 1);
      pkt  = pkt[0:keep-1];
    end else if (kind < 90) begin
      pkt = {};
      pkt.push_back(8'($urandom_range(9, 255)));
      repeat ($urandom_range(0, 6)) pkt.push_back(8'($urandom_range(0, 255)));
    end else begin
      pkt = {};
      repeat ($urandom_range(1, 10)) pkt.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // full-size packet whose zero-length second field sits at offset 256
  task build_long(bit overlong);
    pkt = {8'd2, 8'd0, 8'd251};
    pkt.push_back(cur_tag);
    repeat (250) pkt.push_back(8'($urandom_range(0, 255)));
    pkt.push_back(8'h00);
    pkt.push_back(8'h00);
    if (overlong) repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom_range(0, 255)));
  endtask

  task drain();
    in_valid <= 1'b0;
    while (sb.expected_records.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_tag(bit [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.tag  = v;
    cur_tag = v;
  endtask

  // receiver: random back-pressure, one long hold to fill the block
  initial begin
    int          gap;
    int unsigned results_seen;
    bit          held;
    bit          rx_burst;
    results_seen = 0;
    held         = 1'b0;
    rx_burst     = 1'b0;
    out_ready    = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (results_seen == HOLD_AT && !held) begin
        gap  = HOLD_CYCLES;
        held = 1'b1;
      end else begin
        gap = rx_burst ? 0 : $urandom_range(0, 19);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result({is_status, field_index, field_offset, has_value, field_value,
                       error_kind, last_result});
      results_seen++;
      if (results_seen % 16 == 0) rx_burst = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    int unsigned target;
    bit [7:0]    tags [5];
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = 8'h00;
    in_valid  = 1'b0;
    data_byte = 8'h00;
    last_byte = 1'b0;
    tags      = '{8'h00, 8'hFF, 8'h00, 8'h01, 8'h00};
    tags[2]   = 8'($urandom_range(2, 254));
    tags[4]   = 8'($urandom_range(0, 255));
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed packets with the reset tag
    pkt = {8'h05};                                    // count byte only
    send_packet(1'b0);
    pkt = {8'h00, 8'hFF};                             // no fields
    send_packet(1'b0);
    pkt = {8'hFF, 8'h12};                             // count over limit
    send_packet(1'b0);
    pkt = {8'h01, 8'h00};                             // ends in a length
    send_packet(1'b0);
    pkt = {8'h02, 8'h00, 8'h03, 8'h01, 8'hAB, 8'hCD, 8'h00, 8'h00};
    send_packet(1'b1);
    pkt = {8'h01, 8'h00, 8'h02, 8'h01, 8'h77, 8'hEE}; // short tagged body, trailer
    send_packet(1'b0);
    pkt = {8'h01, 8'hFF, 8'hFF, 8'h00};               // ends in a body
    send_packet(1'b1);

    for (int p = 0; p < 5; p++) begin
      drain();
      write_tag(tags[p]);
      target = items_sent + 40;
      if (p == 2) begin
        build_long(1'b0);
        send_packet(1'b1);
        build_long(1'b1);
        send_packet(1'b1);
      end
      while (items_sent < target) begin
        build_random();
        send_packet($urandom_range(0, 3) == 0);
      end
    end

    drain();
    repeat (16) @(posedge clk);
    if (sb.expected_records.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_records.size()));
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/lpfp_pkg.sv
src/lpfp_ctrl.sv
src/lpfp_dp.sv
src/length_prefixed_field_parser_top.sv
verif/tb_length_prefixed_field_parser_top.sv
